[hw/rtl/suffix_automaton_builder_matcher_macros.svh]
// assertion macros for the suffix automaton builder and matcher
`ifndef SUFFIX_AUTOMATON_BUILDER_MATCHER_MACROS_SVH
`define SUFFIX_AUTOMATON_BUILDER_MATCHER_MACROS_SVH
`ifndef SYNTHESIS
`define SABM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("sabm assertion failed");
`define SABM_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("sabm forbidden condition");
`else
`define SABM_ASSERT(lbl, clk, rstn, prop)
`define SABM_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

[hw/rtl/sabm_pkg.sv]
// shared types and constants of the suffix automaton builder and matcher
package sabm_pkg;
  localparam int unsigned NumStates = 2048;
  localparam int unsigned StateW    = $clog2(NumStates);
  localparam int unsigned CountW    = StateW + 1;
  localparam int unsigned Alphabet  = 26;
  localparam int unsigned SymW      = 5;
  localparam int unsigned LenW      = 11;
  localparam int unsigned MaxText   = 1024;
  localparam int unsigned PosW      = 16;

  localparam logic OpAppend = 1'b0;
  localparam logic OpQuery  = 1'b1;

  typedef enum logic [1:0] {
    StOk   = 2'd0,
    StFull = 2'd1,
    StSat  = 2'd2
  } status_e;

  typedef logic [StateW-1:0] state_t;
  typedef logic [LenW-1:0] len_t;
  typedef logic [Alphabet-1:0][StateW-1:0] row_t;

  // store write and read controls
  typedef struct packed {
    state_t rd_addr;
    logic   row_we;
    state_t row_waddr;
    row_t   row_wdata;
    logic   link_we;
    state_t link_waddr;
    state_t link_wdata;
    logic   len_we;
    state_t len_waddr;
    len_t   len_wdata;
  } store_req_t;

  // registered read data, root link and length read as zero
  typedef struct packed {
    row_t   row;
    state_t link;
    len_t   len;
  } store_rsp_t;
endpackage

[hw/rtl/sabm_if.sv]
// valid/ready channels for input items and result items
interface sabm_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [4:0] symbol;
  logic       query_first;
  modport source (output valid, opcode, symbol, query_first, input ready);
  modport sink (input valid, opcode, symbol, query_first, output ready);
endinterface

interface sabm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [11:0] state_count;
  logic [10:0] match_len;
  logic [10:0] best_len;
  logic [15:0] best_start;
  modport source (output valid, status, state_count, match_len, best_len, best_start,
                  input ready);
  modport sink (input valid, status, state_count, match_len, best_len, best_start,
                output ready);
endinterface

[hw/rtl/sabm_store.sv]
// transition rows, suffix links and state lengths of the automaton
module sabm_store (
  input  logic                clk_i,
  input  sabm_pkg::store_req_t req_i,
  output sabm_pkg::store_rsp_t rsp_o
);
  import sabm_pkg::*;

  row_t   row_mem  [NumStates];
  state_t link_mem [NumStates];
  len_t   len_mem  [NumStates];

  row_t   row_q;
  state_t link_q;
  len_t   len_q;
  logic   rd_root_q;

  // writes and registered reads, one address read for all three arrays
  always_ff @(posedge clk_i) begin
    if (req_i.row_we) row_mem[req_i.row_waddr] <= req_i.row_wdata;
    if (req_i.link_we) link_mem[req_i.link_waddr] <= req_i.link_wdata;
    if (req_i.len_we) len_mem[req_i.len_waddr] <= req_i.len_wdata;
    row_q     <= row_mem[req_i.rd_addr];
    link_q    <= link_mem[req_i.rd_addr];
    len_q     <= len_mem[req_i.rd_addr];
    rd_root_q <= (req_i.rd_addr == '0);
  end

  // the root's link and length are never written: they read as zero
  assign rsp_o.row  = row_q;
  assign rsp_o.link = rd_root_q ? '0 : link_q;
  assign rsp_o.len  = rd_root_q ? '0 : len_q;
endmodule

[hw/rtl/suffix_automaton_builder_matcher.sv]
// Suffix automaton builder and longest-common-substring matcher, one result per item.
// After reset the block sweeps the transition store clean, one state row per cycle, and
// takes no item until the sweep is done. An append walks the suffix links from the last
// state and stops at the root or at the first state that already has the symbol; a clone
// then redirects the walked states to it. An ignored append (invalid symbol, full store or
// text at its limit) visits no state. A query symbol follows suffix links on a mismatch,
// and an invalid query symbol resets the match. A result held by a stalled receiver holds the block.
// Each walk step is one registered read of the shared row/link/length store, which sets the pace.
`include "suffix_automaton_builder_matcher_macros.svh"
module suffix_automaton_builder_matcher (
  input logic    clk_i,
  input logic    rst_ni,
  sabm_in_if.sink    in_i,
  sabm_out_if.source res_o
);
  import sabm_pkg::*;

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_A_WALK = 9'b000000100,
    S_A_CHK  = 9'b000001000,
    S_A_W2   = 9'b000010000,
    S_A_FIN  = 9'b000100000,
    S_Q_WALK = 9'b001000000,
    S_Q_BEST = 9'b010000000,
    S_DONE   = 9'b100000000
  } fsm_e;

  localparam logic [CountW:0] StatesLim = (CountW+1)'(NumStates);
  localparam len_t TextLim = LenW'(MaxText);
  localparam logic [PosW-1:0] PosLast = '1;

  fsm_e state_q, state_d;
  state_t clr_q, clr_d;
  logic [CountW-1:0] su_q, su_d;
  state_t last_q, last_d, p_q, p_d, cur_q, cur_d, qs_q, qs_d, cl_q, cl_d;
  len_t last_len_q, last_len_d, cur_len_q, cur_len_d, lenp_q, lenp_d;
  logic [SymW-1:0] sym_q, sym_d;
  state_t qv_q, qv_d;
  len_t ql_q, ql_d, best_q, best_d;
  logic [PosW-1:0] pos_q, pos_d, idx_q, idx_d, end_q, end_d;
  logic end_vld_q, end_vld_d, follow_q, follow_d;
  status_e status_q, status_d;
  logic out_vld_q, out_vld_d;
  logic [1:0] o_status_q;
  logic [CountW-1:0] o_count_q;
  len_t o_match_q, o_best_q;
  logic [PosW-1:0] o_start_q;

  store_req_t req;
  store_rsp_t rsp;

  sabm_store u_store (.clk_i(clk_i), .req_i(req), .rsp_o(rsp));

  logic in_fire, out_load;
  state_t t_ent;
  row_t nrow;
  len_t l_cur;
  logic [PosW-1:0] pos_b;
  logic [PosW:0] end_p1;
  logic [PosW-1:0] start_w;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid & in_i.ready;
  assign t_ent      = rsp.row[sym_q];
  assign l_cur      = follow_q ? rsp.len : ql_q;

  // best start from best end and best length
  assign end_p1  = {1'b0, end_q} + (PosW+1)'(1);
  assign start_w = (end_vld_q && end_p1 >= (PosW+1)'(best_q)) ?
                   PosW'(end_p1 - (PosW+1)'(best_q)) : '0;

  // sequencer
  always_comb begin
    state_d = state_q; clr_d = clr_q; su_d = su_q; last_d = last_q; p_d = p_q;
    cur_d = cur_q; qs_d = qs_q; cl_d = cl_q; last_len_d = last_len_q;
    cur_len_d = cur_len_q; lenp_d = lenp_q; sym_d = sym_q; qv_d = qv_q; ql_d = ql_q;
    best_d = best_q; pos_d = pos_q; idx_d = idx_q; end_d = end_q; end_vld_d = end_vld_q;
    follow_d = follow_q; status_d = status_q;
    out_load = 1'b0;
    pos_b = pos_q;
    nrow = rsp.row;
    req = '0;
    req.rd_addr = p_q;
    unique case (state_q)
      S_CLEAR: begin
        req.row_we = 1'b1;
        req.row_waddr = clr_q;
        clr_d = clr_q + StateW'(1);
        if (clr_q == '1) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          sym_d = in_i.symbol;
          if (in_i.opcode == OpAppend) begin
            if (in_i.symbol >= SymW'(Alphabet) ||
                ({1'b0, su_q} + (CountW+1)'(2)) > StatesLim || last_len_q >= TextLim) begin
              status_d = StFull;
              state_d = S_DONE;
            end else begin
              status_d = StOk;
              cur_d = su_q[StateW-1:0];
              su_d = su_q + CountW'(1);
              cur_len_d = last_len_q + LenW'(1);
              req.len_we = 1'b1;
              req.len_waddr = su_q[StateW-1:0];
              req.len_wdata = last_len_q + LenW'(1);
              p_d = last_q;
              req.rd_addr = last_q;
              state_d = S_A_WALK;
            end
          end else begin
            // query restart, then position bookkeeping
            qv_d = qv_q;
            ql_d = ql_q;
            if (in_i.query_first) begin
              qv_d = '0; ql_d = '0; best_d = '0; end_vld_d = 1'b0; pos_b = '0;
            end
            idx_d = pos_b;
            if (pos_b == PosLast) begin
              status_d = StSat;
              pos_d = pos_b;
            end else begin
              status_d = StOk;
              pos_d = pos_b + PosW'(1);
            end
            follow_d = 1'b0;
            if (in_i.symbol >= SymW'(Alphabet)) begin
              qv_d = '0; ql_d = '0;
              state_d = S_Q_BEST;
            end else begin
              req.rd_addr = qv_d;
              state_d = S_Q_WALK;
            end
          end
        end
      end
      S_A_WALK: begin
        if (t_ent != '0) begin
          qs_d = t_ent;
          lenp_d = rsp.len;
          req.rd_addr = t_ent;
          state_d = S_A_CHK;
        end else begin
          nrow[sym_q] = cur_q;
          req.row_we = 1'b1;
          req.row_waddr = p_q;
          req.row_wdata = nrow;
          if (p_q == '0) begin
            req.link_we = 1'b1;
            req.link_waddr = cur_q;
            req.link_wdata = '0;
            last_d = cur_q; last_len_d = cur_len_q;
            state_d = S_DONE;
          end else begin
            p_d = rsp.link;
            req.rd_addr = rsp.link;
          end
        end
      end
      S_A_CHK: begin
        if (lenp_q + LenW'(1) == rsp.len) begin
          req.link_we = 1'b1;
          req.link_waddr = cur_q;
          req.link_wdata = qs_q;
          last_d = cur_q; last_len_d = cur_len_q;
          state_d = S_DONE;
        end else begin
          // clone q into a fresh state
          cl_d = su_q[StateW-1:0];
          su_d = su_q + CountW'(1);
          req.row_we = 1'b1;
          req.row_waddr = su_q[StateW-1:0];
          req.row_wdata = rsp.row;
          req.link_we = 1'b1;
          req.link_waddr = su_q[StateW-1:0];
          req.link_wdata = rsp.link;
          req.len_we = 1'b1;
          req.len_waddr = su_q[StateW-1:0];
          req.len_wdata = lenp_q + LenW'(1);
          req.rd_addr = p_q;
          state_d = S_A_W2;
        end
      end
      S_A_W2: begin
        if (t_ent != qs_q || p_q == '0) begin
          if (t_ent == qs_q) begin
            nrow[sym_q] = cl_q;
            req.row_we = 1'b1;
            req.row_waddr = p_q;
            req.row_wdata = nrow;
          end
          req.link_we = 1'b1;
          req.link_waddr = qs_q;
          req.link_wdata = cl_q;
          state_d = S_A_FIN;
        end else begin
          nrow[sym_q] = cl_q;
          req.row_we = 1'b1;
          req.row_waddr = p_q;
          req.row_wdata = nrow;
          p_d = rsp.link;
          req.rd_addr = rsp.link;
        end
      end
      S_A_FIN: begin
        req.link_we = 1'b1;
        req.link_waddr = cur_q;
        req.link_wdata = cl_q;
        last_d = cur_q; last_len_d = cur_len_q;
        state_d = S_DONE;
      end
      S_Q_WALK: begin
        req.rd_addr = qv_q;
        if (qv_q != '0 && t_ent == '0) begin
          qv_d = rsp.link;
          ql_d = l_cur;
          follow_d = 1'b1;
          req.rd_addr = rsp.link;
        end else begin
          if (t_ent != '0) begin
            qv_d = t_ent;
            ql_d = (l_cur == '1) ? l_cur : l_cur + LenW'(1);
          end else begin
            ql_d = l_cur;
          end
          state_d = S_Q_BEST;
        end
      end
      S_Q_BEST: begin
        if (ql_q > best_q) begin
          best_d = ql_q; end_d = idx_q; end_vld_d = 1'b1;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_vld_q || res_o.ready) begin
          out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // result register
  always_comb begin
    out_vld_d = out_vld_q;
    if (res_o.ready) out_vld_d = 1'b0;
    if (out_load) out_vld_d = 1'b1;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; clr_q <= '0; su_q <= CountW'(1); last_q <= '0;
      last_len_q <= '0; qv_q <= '0; ql_q <= '0; best_q <= '0; pos_q <= '0;
      end_q <= '0; end_vld_q <= 1'b0; out_vld_q <= 1'b0; follow_q <= 1'b0;
      status_q <= StOk;
    end else begin
      state_q <= state_d; clr_q <= clr_d; su_q <= su_d; last_q <= last_d;
      last_len_q <= last_len_d; qv_q <= qv_d; ql_q <= ql_d; best_q <= best_d;
      pos_q <= pos_d; end_q <= end_d; end_vld_q <= end_vld_d; out_vld_q <= out_vld_d;
      follow_q <= follow_d; status_q <= status_d;
    end
  end

  // working and result payload
  always_ff @(posedge clk_i) begin
    p_q <= p_d; cur_q <= cur_d; qs_q <= qs_d; cl_q <= cl_d; cur_len_q <= cur_len_d;
    lenp_q <= lenp_d; sym_q <= sym_d; idx_q <= idx_d;
    if (out_load) begin
      o_status_q <= status_q;
      o_count_q  <= su_q;
      o_match_q  <= ql_q;
      o_best_q   <= best_q;
      o_start_q  <= start_w;
    end
  end

  assign res_o.valid       = out_vld_q;
  assign res_o.status      = o_status_q;
  assign res_o.state_count = o_count_q;
  assign res_o.match_len   = o_match_q;
  assign res_o.best_len    = o_best_q;
  assign res_o.best_start  = o_start_q;

  `SABM_ASSERT_NEVER(a_su_bound, clk_i, rst_ni, su_q > CountW'(NumStates))
  `SABM_ASSERT(a_busy_after_take, clk_i, rst_ni, in_fire |=> !in_i.ready)
  `SABM_ASSERT(a_last_in_use, clk_i, rst_ni, {1'b0, last_q} < su_q)
  `SABM_ASSERT(a_query_in_use, clk_i, rst_ni, {1'b0, qv_q} < su_q)
endmodule
